/* hdl/ffba_pkg.sv */
// Shared types, widths and codes for the first-fit block bitmap allocator.
`default_nettype none

package ffba_pkg;

  localparam int NUM_BLOCKS_DEF    = 1024;
  localparam int MAP_WORD_BITS_DEF = 32;

  localparam int BLOCK_W  = 10;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic clr_step;
    logic start;
    logic scan;
    logic grab;
    logic set_full;
    logic set_range;
    logic div;
    logic frd;
    logic fwr;
    logic awr;
    logic out_load;
  } ffba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic chk_vld;
    logic hit;
    logic full;
    logic range_err;
    logic slot_free;
  } ffba_sts_t;

endpackage

`default_nettype wire

/* hdl/ffba_ctrl.sv */
// Controller state machine sequencing clear, scan, free and result beats.
`default_nettype none

module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      kind,
  output logic           in_ready,
  input  wire ffba_sts_t sts,
  output ffba_cmd_t      cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    SCAN,
    AWR,
    FDIV,
    FRD,
    FWR,
    FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = IDLE;
      end
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = (kind == KIND_FREE) ? FDIV : SCAN;
        end
      end
      SCAN: begin
        if (sts.chk_vld && sts.hit) begin
          cmd.grab   = 1'b1;
          state_next = AWR;
        end else if (sts.chk_vld && sts.full) begin
          cmd.set_full = 1'b1;
          state_next   = FIN;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      AWR: begin
        cmd.awr    = 1'b1;
        state_next = FIN;
      end
      FDIV: begin
        if (sts.range_err) begin
          cmd.set_range = 1'b1;
          state_next    = FIN;
        end else begin
          cmd.div    = 1'b1;
          state_next = FRD;
        end
      end
      FRD: begin
        cmd.frd    = 1'b1;
        state_next = FWR;
      end
      FWR: begin
        cmd.fwr    = 1'b1;
        state_next = FIN;
      end
      FIN: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/ffba_dp.sv */
// Datapath: allocation map memory, word scanner, free index split and output register.
`default_nettype none

module ffba_dp
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data,
  input  wire logic                kind,
  input  wire logic [BLOCK_W-1:0]  block_to_free,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [BLOCK_W-1:0]       granted_block,
  output logic [STATUS_W-1:0]      status,
  input  wire ffba_cmd_t           cmd,
  output ffba_sts_t                sts
);

  localparam int W     = MAP_WORD_BITS;
  localparam int DEPTH = (NUM_BLOCKS + W - 1) / W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW0   = $clog2(DEPTH * W + W + 1);
  localparam int VW    = (VW0 > CFG_W + 1) ? VW0 : CFG_W + 1;
  localparam int BPW   = $clog2(W);
  localparam int SH    = 20;
  localparam int PW    = SH + BLOCK_W;
  localparam int RECIP = ((1 << SH) + W - 1) / W;

  logic [W-1:0]        mem [DEPTH];
  logic [W-1:0]        rd_data;

  logic [CFG_W-1:0]    biu;
  logic [VW-1:0]       limit;

  logic [AW-1:0]       clr_addr;
  logic [CW-1:0]       scan_addr;
  logic [VW-1:0]       scan_base;
  logic [AW-1:0]       chk_addr;
  logic [VW-1:0]       chk_base;
  logic                chk_vld;

  logic                req_kind;
  logic [BLOCK_W-1:0]  idx;
  logic [AW-1:0]       faddr;
  logic [BPW-1:0]      bitpos;

  logic [AW-1:0]       wr_addr;
  logic [W-1:0]        wr_data;

  logic [BLOCK_W-1:0]  res_grant;
  logic [STATUS_W-1:0] res_status;

  logic [VW-1:0]       rem;
  logic [W-1:0]        mask;
  logic [W-1:0]        free_vec;
  logic [W-1:0]        low_one;
  logic [BPW-1:0]      hit_pos;
  logic                hit;
  logic [PW-1:0]       prod;
  logic [BLOCK_W-1:0]  qw;
  logic [BLOCK_W-1:0]  rmd;

  assign limit = (VW'(biu) > VW'(NUM_BLOCKS)) ? VW'(NUM_BLOCKS) : VW'(biu);

  always_comb begin
    rem = (limit > chk_base) ? (limit - chk_base) : '0;
    for (int b = 0; b < W; b++) begin
      mask[b] = VW'(b) < rem;
    end
    free_vec = ~rd_data & mask;
    low_one  = free_vec & (~free_vec + W'(1));
    hit      = |free_vec;
    hit_pos  = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (free_vec[b]) hit_pos = BPW'(b);
    end
  end

  assign prod = PW'(idx) * PW'(RECIP);
  assign qw   = BLOCK_W'(faddr) * BLOCK_W'(W);
  assign rmd  = idx - qw;

  assign sts.clr_last  = clr_addr == AW'(DEPTH - 1);
  assign sts.chk_vld   = chk_vld;
  assign sts.hit       = hit;
  assign sts.full      = !hit && ((chk_base + VW'(W)) >= limit);
  assign sts.range_err = VW'(idx) >= limit;
  assign sts.slot_free = !out_valid || out_ready;

  // map write port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr] <= '0;
    end else if (cmd.awr) begin
      mem[wr_addr] <= wr_data;
    end else if (cmd.fwr) begin
      mem[faddr] <= rd_data & ~(W'(1) << bitpos);
    end
  end

  // map read port
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= mem[scan_addr[AW-1:0]];
    end else if (cmd.frd) begin
      rd_data <= mem[faddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      biu       <= CFG_RESET;
      clr_addr  <= '0;
      scan_addr <= '0;
      scan_base <= '0;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) biu <= cfg_wr_data;
      if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
      if (cmd.start) begin
        scan_addr <= '0;
        scan_base <= '0;
        chk_vld   <= 1'b0;
      end else if (cmd.scan) begin
        scan_addr <= scan_addr + CW'(1);
        scan_base <= scan_base + VW'(W);
        chk_vld   <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_kind <= kind;
      idx      <= block_to_free;
    end
    if (cmd.scan) begin
      chk_addr <= scan_addr[AW-1:0];
      chk_base <= scan_base;
    end
    if (cmd.grab) begin
      wr_addr    <= chk_addr;
      wr_data    <= rd_data | low_one;
      res_grant  <= BLOCK_W'(chk_base + VW'(hit_pos));
      res_status <= ST_OK;
    end
    if (cmd.set_full || cmd.set_range || cmd.fwr) begin
      res_grant <= '0;
    end
    if (cmd.set_full) res_status <= ST_FULL;
    if (cmd.set_range) res_status <= ST_RANGE;
    if (cmd.fwr) res_status <= (req_kind == KIND_FREE) ? ST_OK : ST_FULL;
    if (cmd.div) faddr <= AW'(prod[SH +: BLOCK_W]);
    if (cmd.frd) bitpos <= BPW'(rmd);
    if (cmd.out_load) begin
      granted_block <= res_grant;
      status        <= res_status;
    end
  end

endmodule

`default_nettype wire

/* hdl/first_fit_block_bitmap_allocator.sv */
// Top level of the first-fit block bitmap allocator.
//
// Request channel (in_valid/in_ready): kind selects allocate or free; block_to_free names the
// block to release on a free beat. Result channel (out_valid/out_ready): granted_block and
// status, one result beat per request, in request order.
// Configuration: cfg_wr_en writes cfg_wr_data into blocks_in_use at once; write only when idle.
// Values above NUM_BLOCKS act as NUM_BLOCKS.
// The map is one memory word of MAP_WORD_BITS blocks per entry, read through one registered
// port. Allocate walks it one word a cycle from word 0 and stops at the first free block or
// at the limit. Free goes through range check, index split, read, write and result.
// One request is in work at a time; the next is accepted the cycle after a result is loaded.
// Reset clears the map with one pass over every map word, during which in_ready stays low;
// configuration writes are taken as ever.
// A stalled receiver holds the result in the output register; the following request is still
// accepted and worked, and its result waits until the output register frees.
`default_nettype none

module first_fit_block_bitmap_allocator
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                kind,
  input  wire logic [BLOCK_W-1:0]  block_to_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [BLOCK_W-1:0]       granted_block,
  output logic [STATUS_W-1:0]      status
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .kind          (kind),
    .block_to_free (block_to_free),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .granted_block (granted_block),
    .status        (status),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

/* test/first_fit_block_bitmap_allocator_test.sv */
// Self-checking testbench for the first-fit block bitmap allocator, with its own allocation map.
module first_fit_block_bitmap_allocator_test;
  import ffba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PER_PHASE = 216;

  typedef struct packed {
    logic                k;
    logic [BLOCK_W-1:0]  idx;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  blk;
    logic [STATUS_W-1:0] st;
  } grant_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                kind = KIND_ALLOC;
  logic [BLOCK_W-1:0]  block_to_free = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BLOCK_W-1:0]  granted_block;
  logic [STATUS_W-1:0] status;

  req_t   pending[$];
  grant_t grants_due[$];
  int     in_flight = 0;
  int     errors = 0;
  int     cycles = 0;
  int     tx_gap_pct = 0;
  int     rx_stall_pct = 0;

  logic [NUM_BLOCKS_DEF-1:0] used_map = '0;
  logic [CFG_W-1:0]          limit_reg = CFG_RESET;

  first_fit_block_bitmap_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .block_to_free (block_to_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_block (granted_block),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic grant_t serve_request(input logic k, input logic [BLOCK_W-1:0] idx);
    int     lim;
    grant_t r;
    lim = (limit_reg > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(limit_reg);
    r.blk = '0;
    if (k == KIND_ALLOC) begin
      r.st = ST_FULL;
      for (int i = 0; i < lim; i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          r.blk = BLOCK_W'(i);
          r.st = ST_OK;
          break;
        end
      end
    end else if (int'(idx) >= lim) begin
      r.st = ST_RANGE;
    end else begin
      used_map[idx] = 1'b0;
      r.st = ST_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("cycle %0d: %s", cycles, what);
  endtask

  task automatic push_req(input logic k, input logic [BLOCK_W-1:0] idx);
    req_t r;
    r.k = k;
    r.idx = idx;
    pending.push_back(r);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending.size() != 0 || in_flight != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  // frees lean toward low blocks, where first fit packs its grants
  task automatic queue_random(input int count, input int alloc_pct);
    req_t r;
    int   lim;
    lim = (limit_reg > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(limit_reg);
    repeat (count) begin
      r.idx = BLOCK_W'($urandom_range(NUM_BLOCKS_DEF - 1));
      if ($urandom_range(99) < alloc_pct) begin
        r.k = KIND_ALLOC;
      end else begin
        r.k = KIND_FREE;
        if (lim > 0 && $urandom_range(99) < 45)
          r.idx = BLOCK_W'($urandom_range(((lim < 48) ? lim : 48) - 1));
        else if (lim > 0 && $urandom_range(99) < 70)
          r.idx = BLOCK_W'($urandom_range(lim - 1));
      end
      pending.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        grants_due.push_back(serve_request(kind, block_to_free));
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin : next_beat
          req_t r;
          r = pending.pop_front();
          in_flight++;
          in_valid <= 1'b1;
          kind <= r.k;
          block_to_free <= r.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    grant_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = grants_due.pop_front();
          in_flight--;
          if (granted_block !== want.blk)
            report_mismatch($sformatf("granted_block %0d, expected %0d",
                                      granted_block, want.blk));
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        end
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_block_bitmap_allocator_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] limits [6];
    int               alloc_pcts [6];
    limits = '{11'd1024, 11'd37, 11'd1, 11'd2047, 11'd8, 11'd0};
    alloc_pcts = '{70, 60, 55, 65, 55, 60};
    limits[5] = CFG_W'($urandom_range(2047));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tx_gap_pct = 24;
    rx_stall_pct = 87;

    // reset limit: grant, free, reuse, free of a free block, top index
    push_req(KIND_ALLOC, '0);
    push_req(KIND_ALLOC, '1);
    push_req(KIND_FREE, '0);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, '1);
    push_req(KIND_FREE, 10'd1);
    push_req(KIND_ALLOC, '1);

    // no blocks in use
    write_limit(11'd0);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, '0);
    push_req(KIND_FREE, '1);

    // limit beyond the map
    write_limit(11'h7FF);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, '1);
    push_req(KIND_FREE, '0);

    // tiny limit: full and out of range
    write_limit(11'd2);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, 10'd2);
    push_req(KIND_FREE, 10'd1);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_ALLOC, '1);
    push_req(KIND_FREE, '0);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        wait_idle();
        tx_gap_pct = 87;
        rx_stall_pct = 24;
      end else if (p == 4) begin
        wait_idle();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      write_limit(limits[p]);
      queue_random(RANDOM_PER_PHASE, alloc_pcts[p]);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (grants_due.size() != 0)
      report_mismatch("requests left without a result");
    if (errors == 0)
      $display("first_fit_block_bitmap_allocator_test OK");
    else
      $display("first_fit_block_bitmap_allocator_test NOT OK");
    $finish;
  end

endmodule
